/* rtl/bpc_pkg.sv */
package bpc_pkg;

  localparam int HistoryBitsDefault = 8;
  localparam int CfgW               = 8;
  localparam int CountW             = 8;
  localparam int EventW             = 3;
  localparam int ApbAddrW           = 5;
  localparam int ApbDataW           = 32;

  typedef enum logic [EventW-1:0] {
    EvNone     = 3'd0,
    EvDown     = 3'd1,
    EvLong     = 3'd2,
    EvShort    = 3'd3,
    EvReleased = 3'd4,
    EvPressed  = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    RegPressMask      = 3'd0,
    RegPressPattern   = 3'd1,
    RegReleaseMask    = 3'd2,
    RegReleasePattern = 3'd3,
    RegDownValue      = 3'd4,
    RegUpValue        = 3'd5,
    RegLongThreshold  = 3'd6,
    RegCountLimit     = 3'd7
  } reg_idx_e;

  localparam logic [CfgW-1:0] PressMaskRst      = 8'd199;
  localparam logic [CfgW-1:0] PressPatternRst   = 8'd7;
  localparam logic [CfgW-1:0] ReleaseMaskRst    = 8'd199;
  localparam logic [CfgW-1:0] ReleasePatternRst = 8'd192;
  localparam logic [CfgW-1:0] DownValueRst      = 8'd255;
  localparam logic [CfgW-1:0] UpValueRst        = 8'd0;
  localparam logic [CfgW-1:0] LongThresholdRst  = 8'd100;
  localparam logic [CfgW-1:0] CountLimitRst     = 8'd200;

  typedef struct packed {
    logic [CfgW-1:0] press_mask;
    logic [CfgW-1:0] press_pattern;
    logic [CfgW-1:0] release_mask;
    logic [CfgW-1:0] release_pattern;
    logic [CfgW-1:0] down_value;
    logic [CfgW-1:0] up_value;
    logic [CfgW-1:0] long_threshold;
    logic [CfgW-1:0] count_limit;
  } cfg_t;

  typedef struct packed {
    event_e              event_res;
    logic [CountW-1:0]   held_count;
  } result_t;

endpackage

/* rtl/bpc_regs.sv */
module bpc_regs
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;
  logic [CfgW-1:0] rd_val;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegPressMask:      cfg_d.press_mask      = pwdata[CfgW-1:0];
        RegPressPattern:   cfg_d.press_pattern   = pwdata[CfgW-1:0];
        RegReleaseMask:    cfg_d.release_mask    = pwdata[CfgW-1:0];
        RegReleasePattern: cfg_d.release_pattern = pwdata[CfgW-1:0];
        RegDownValue:      cfg_d.down_value      = pwdata[CfgW-1:0];
        RegUpValue:        cfg_d.up_value        = pwdata[CfgW-1:0];
        RegLongThreshold:  cfg_d.long_threshold  = pwdata[CfgW-1:0];
        RegCountLimit:     cfg_d.count_limit     = pwdata[CfgW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegPressMask:      rd_val = cfg_q.press_mask;
      RegPressPattern:   rd_val = cfg_q.press_pattern;
      RegReleaseMask:    rd_val = cfg_q.release_mask;
      RegReleasePattern: rd_val = cfg_q.release_pattern;
      RegDownValue:      rd_val = cfg_q.down_value;
      RegUpValue:        rd_val = cfg_q.up_value;
      RegLongThreshold:  rd_val = cfg_q.long_threshold;
      RegCountLimit:     rd_val = cfg_q.count_limit;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = ApbDataW'(rd_val);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_mask      <= PressMaskRst;
      cfg_q.press_pattern   <= PressPatternRst;
      cfg_q.release_mask    <= ReleaseMaskRst;
      cfg_q.release_pattern <= ReleasePatternRst;
      cfg_q.down_value      <= DownValueRst;
      cfg_q.up_value        <= UpValueRst;
      cfg_q.long_threshold  <= LongThresholdRst;
      cfg_q.count_limit     <= CountLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/bpc_classify.sv */
module bpc_classify
  import bpc_pkg::*;
#(
  parameter int HISTORY_BITS = HistoryBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  logic    sample_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  // config values are cut or zero-extended to the history width
  localparam int ExtW = (HISTORY_BITS > CfgW) ? HISTORY_BITS : CfgW;

  logic [ExtW-1:0]         pm_ext, pp_ext, rm_ext, rp_ext, dv_ext, uv_ext;
  logic [HISTORY_BITS-1:0] pm, pp, rm, rp, dv, uv;
  logic [HISTORY_BITS-1:0] history_q, history_d, hist_shift;
  logic [CountW-1:0]       hold_q, hold_d;
  event_e                  ev;

  assign pm_ext = ExtW'(cfg_i.press_mask);
  assign pp_ext = ExtW'(cfg_i.press_pattern);
  assign rm_ext = ExtW'(cfg_i.release_mask);
  assign rp_ext = ExtW'(cfg_i.release_pattern);
  assign dv_ext = ExtW'(cfg_i.down_value);
  assign uv_ext = ExtW'(cfg_i.up_value);

  assign pm = pm_ext[HISTORY_BITS-1:0];
  assign pp = pp_ext[HISTORY_BITS-1:0];
  assign rm = rm_ext[HISTORY_BITS-1:0];
  assign rp = rp_ext[HISTORY_BITS-1:0];
  assign dv = dv_ext[HISTORY_BITS-1:0];
  assign uv = uv_ext[HISTORY_BITS-1:0];

  assign hist_shift = {history_q[HISTORY_BITS-2:0], sample_i};

  always_comb begin
    history_d = hist_shift;
    hold_d    = hold_q;
    ev        = EvNone;
    if (hist_shift == dv) begin
      if (hold_q < cfg_i.count_limit) begin
        hold_d = hold_q + CountW'(1);
      end
      ev = EvDown;
    end else if (hist_shift == uv && hold_q != '0) begin
      ev     = (hold_q > cfg_i.long_threshold) ? EvLong : EvShort;
      hold_d = '0;
    end else if ((hist_shift & rm) == rp) begin
      history_d = uv;
      ev        = EvReleased;
    end else if ((hist_shift & pm) == pp) begin
      history_d = dv;
      ev        = EvPressed;
    end
  end

  assign res_o.event_res  = ev;
  assign res_o.held_count = hold_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q <= '0;
      hold_q    <= '0;
    end else if (accept_i) begin
      history_q <= history_d;
      hold_q    <= hold_d;
    end
  end

endmodule

/* rtl/bpc_out_buf.sv */
module bpc_out_buf
  import bpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take = out_valid_q & ~stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept_i) begin
      if (!out_valid_q || take) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        // output held by receiver, park the item in the skid stage
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

/* rtl/button_press_classifier_core.sv */
// button press classifier: debounces one raw button level and reports
// down, long press, short press, released and pressed events.
//
// input channel: one sample item per tick on sample_i, taken at a clock
// edge with valid_i high and stall_o low. output channel: one result item
// per input item on event_res_o / held_count_o, taken at an edge with
// valid_o high and stall_i low.
// throughput is one item per cycle unless stalled: shift, pattern compare
// and hold counter update all sit between the history/counter registers
// and the output register. when the receiver stalls, the output register
// holds its item and one more item is caught in a skid stage; stall_o
// rises only once that stage is full, and it comes straight from a flop.
// reset clears history, hold counter and both output stages and loads the
// default patterns into the apb registers (byte address 4 * index, 8 data
// bits each, pready tied high). registers are to be written only while
// idle; the user must see to it, the block does not enforce it.
module button_press_classifier_core
  import bpc_pkg::*;
#(
  parameter int HISTORY_BITS = HistoryBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                sample_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [EventW-1:0]   event_res_o,
  output logic [CountW-1:0]   held_count_o
);

  cfg_t    cfg;
  result_t res_new, res_out;
  logic    accept;
  logic    full;

  assign stall_o = full;
  assign accept  = valid_i & ~full;

  bpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpc_classify #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .res_o    (res_new)
  );

  bpc_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .res_i    (res_new),
    .full_o   (full),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .res_o    (res_out)
  );

  assign event_res_o  = EventW'(res_out.event_res);
  assign held_count_o = res_out.held_count;

endmodule

/* rtl/bpc_checker.sv */
module bpc_checker
  import bpc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              stall_o,
  input logic              valid_o,
  input logic              stall_i,
  input logic [EventW-1:0] event_res_o,
  input logic [CountW-1:0] held_count_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output item dropped while stalled");

  // a press report always leaves the hold counter cleared
  a_press_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (event_res_o == EvLong || event_res_o == EvShort)
      |-> held_count_o == '0)
    else $error("press reported with nonzero hold count");

  // a new result only appears after an input item was taken
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(valid_i && !stall_o))
    else $error("output item without accepted input item");

  // backpressure only when the output stage is occupied and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i) && valid_o)
    else $error("input stalled without output stall");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (valid_i),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .event_res_o  (event_res_o),
  .held_count_o (held_count_o)
);
